// ===== rtl/core/htk_pkg.sv =====
// Shared types, constants and helpers for the HTTP request tokenizer.
`default_nettype none

package htk_pkg;

    typedef enum logic [8:0] {
        PH_METHOD  = 9'b0_0000_0001,
        PH_PATH    = 9'b0_0000_0010,
        PH_QNAME   = 9'b0_0000_0100,
        PH_QVALUE  = 9'b0_0000_1000,
        PH_VERSION = 9'b0_0001_0000,
        PH_LINE    = 9'b0_0010_0000,
        PH_HNAME   = 9'b0_0100_0000,
        PH_HVALUE  = 9'b0_1000_0000,
        PH_BODY    = 9'b1_0000_0000
    } phase_t;

    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_QNAME   = 3'd2;
    localparam logic [2:0] KIND_QVALUE  = 3'd3;
    localparam logic [2:0] KIND_HNAME   = 3'd4;
    localparam logic [2:0] KIND_HVALUE  = 3'd5;
    localparam logic [2:0] KIND_BODY    = 3'd6;
    localparam logic [2:0] KIND_VERSION = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_BAD_VER   = 2'd2;
    localparam logic [1:0] ST_BAD_QUERY = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] VER_LEN  = 4'd8;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] ver_pos;
        logic       ver_mismatch;
        logic       query_fresh;
        logic [1:0] err;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic       field_end;
        logic       request_end;
        logic [1:0] status;
    } token_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_METHOD,
        ver_pos:      4'd0,
        ver_mismatch: 1'b0,
        query_fresh:  1'b0,
        err:          ST_OK
    };

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            default: ch = 8'h31;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kind_of_phase(input phase_t ph);
        logic [2:0] k;
        unique case (ph)
            PH_METHOD:  k = KIND_METHOD;
            PH_PATH:    k = KIND_PATH;
            PH_QNAME:   k = KIND_QNAME;
            PH_QVALUE:  k = KIND_QVALUE;
            PH_VERSION: k = KIND_VERSION;
            PH_LINE:    k = KIND_HNAME;
            PH_HNAME:   k = KIND_HNAME;
            PH_HVALUE:  k = KIND_HVALUE;
            default:    k = KIND_BODY;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htk_step.sv =====
// Per-byte phase update and token tagging for the HTTP request tokenizer.
`default_nettype none

module htk_step (
    input  wire  htk_pkg::parse_state_t cur,
    input  wire  logic [7:0]            in_byte,
    input  wire  logic                  last,
    output htk_pkg::parse_state_t       nxt,
    output htk_pkg::token_t             res
);
    import htk_pkg::*;

    parse_state_t s;
    logic         valid;
    logic         fend;

    always_comb
    begin
        s     = cur;
        valid = 1'b0;
        fend  = 1'b0;
        if (cur.phase == PH_BODY)
        begin
            valid = 1'b1;
        end
        else if (in_byte == CH_CR)
        begin
            valid = 1'b0;
        end
        else
        begin
            unique case (cur.phase)
                PH_METHOD:
                begin
                    if (in_byte == CH_SPACE)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_PATH;
                    end
                    else
                        valid = 1'b1;
                end
                PH_PATH:
                begin
                    if (in_byte == CH_SPACE)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_VERSION;
                    end
                    else if (in_byte == CH_QMARK)
                    begin
                        fend          = 1'b1;
                        s.phase       = PH_QNAME;
                        s.query_fresh = 1'b1;
                    end
                    else
                        valid = 1'b1;
                end
                PH_QNAME:
                begin
                    s.query_fresh = 1'b0;
                    if (in_byte == CH_EQUAL)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_QVALUE;
                    end
                    else if (in_byte == CH_SPACE)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_VERSION;
                        if (s.err == ST_OK)
                            s.err = ST_BAD_QUERY;
                    end
                    else
                        valid = 1'b1;
                end
                PH_QVALUE:
                begin
                    if (in_byte == CH_AMP)
                    begin
                        fend          = 1'b1;
                        s.phase       = PH_QNAME;
                        s.query_fresh = 1'b1;
                    end
                    else if (in_byte == CH_SPACE)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_VERSION;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        fend          = 1'b1;
                        s.phase       = PH_QNAME;
                        s.query_fresh = 1'b1;
                        if (s.err == ST_OK)
                            s.err = ST_BAD_QUERY;
                    end
                    else
                        valid = 1'b1;
                end
                PH_VERSION:
                begin
                    if (in_byte == CH_LF)
                    begin
                        fend = 1'b1;
                        if ((cur.ver_pos != VER_LEN || cur.ver_mismatch) && s.err == ST_OK)
                            s.err = ST_BAD_VER;
                        s.ver_pos      = 4'd0;
                        s.ver_mismatch = 1'b0;
                        s.phase        = PH_LINE;
                    end
                    else
                    begin
                        valid = 1'b1;
                        if (cur.ver_pos < VER_LEN)
                        begin
                            if (in_byte != version_char(cur.ver_pos[2:0]))
                                s.ver_mismatch = 1'b1;
                            s.ver_pos = cur.ver_pos + 4'd1;
                        end
                        else
                            s.ver_mismatch = 1'b1;
                    end
                end
                PH_LINE:
                begin
                    if (in_byte == CH_LF)
                        s.phase = PH_BODY;
                    else if (in_byte == CH_COLON)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_HVALUE;
                    end
                    else
                    begin
                        valid   = 1'b1;
                        s.phase = PH_HNAME;
                    end
                end
                PH_HNAME:
                begin
                    if (in_byte == CH_COLON)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_HVALUE;
                    end
                    else
                        valid = 1'b1;
                end
                PH_HVALUE:
                begin
                    if (in_byte == CH_LF)
                    begin
                        fend    = 1'b1;
                        s.phase = PH_LINE;
                    end
                    else
                        valid = 1'b1;
                end
                default:
                begin
                    valid   = 1'b1;
                    s.phase = PH_BODY;
                end
            endcase
        end

        res.out_byte    = in_byte;
        res.byte_valid  = valid;
        res.field_kind  = kind_of_phase(cur.phase);
        res.field_end   = fend;
        res.request_end = last;
        res.status      = s.err;
        if (last && s.err == ST_OK && s.phase != PH_BODY)
            res.status = ST_TRUNC;

        nxt = last ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

// ===== rtl/core/http_request_tokenizer_unit.sv =====
// Top level of the HTTP request tokenizer: input register, phase register, result register.
`default_nettype none

// Tags one request byte per clock, while the master side accepts, with its field kind,
// content flag and field end, and carries the latched status (truncation, bad version,
// bad query). A byte is registered in the input register and then, once the master
// side is free, in the result register that drives it. The state returns to its reset
// value after each byte marked with tlast.
module http_request_tokenizer_unit (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire  logic        s_tlast,   // last
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [8] byte_valid, [9] field_end,
                                         // [11:10] status, [15:12] zero
    output logic [2:0]        m_tuser,   // [2:0] field_kind
    output logic              m_tlast    // request_end
);
    import htk_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    token_t       res_reg;
    token_t       res_next;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         advance;
    logic         take;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign take           = s_tvalid && s_tready;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    htk_step u_step (
        .cur     (state_reg),
        .in_byte (in_byte_reg),
        .last    (in_last_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.status, res_reg.field_end, res_reg.byte_valid,
                       res_reg.out_byte};
    assign m_tuser  = res_reg.field_kind;
    assign m_tlast  = res_reg.request_end;

`ifndef ASSERT_OFF
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg == STATE_RESET)
        else $error("state not cleared after request end");

    a_ver_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ver_pos <= VER_LEN)
        else $error("version position beyond length");

    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.err != ST_OK && !(advance && in_last_reg)
        |=> state_reg.err == $past(state_reg.err))
        else $error("latched error changed");

    a_body_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.phase == PH_BODY |=> res_reg.byte_valid && !res_reg.field_end)
        else $error("body byte not tagged as content");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> state_reg == $past(state_reg))
        else $error("state moved without a byte");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_http_request_tokenizer_unit.sv =====
// Testbench for http_request_tokenizer_unit: directed and random requests checked per word.
`timescale 1ns / 100ps

module tb_http_request_tokenizer_unit;

    import htk_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_WORDS   = 1100;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int DIR_ROWS       = 24;

    localparam logic [63:0] VERSION_TEXT = "HTTP/1.1";

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_t;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       typed;
        logic       valid;
        logic [2:0] kind;
        logic       fend;
        logic [1:0] status;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // parser state mirrored by the predictor
    phase_t     ph          = PH_METHOD;
    logic [3:0] ver_cnt     = 4'd0;
    logic       ver_bad     = 1'b0;
    logic       q_fresh     = 1'b0;
    logic [1:0] err_latched = ST_OK;

    token_t     expected_tokens[$];
    logic       row_typed = 1'b0;
    token_t     row_token = '0;
    flow_t      flow      = FLOW_FREE;
    logic       hold_arm  = 1'b0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    int         mismatches  = 0;
    logic [7:0] req_bytes[$];
    dir_row_t   dir_rows [DIR_ROWS];

    http_request_tokenizer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [2:0] phase_kind(input phase_t p);
        case (p)
            PH_METHOD:  return KIND_METHOD;
            PH_PATH:    return KIND_PATH;
            PH_QNAME:   return KIND_QNAME;
            PH_QVALUE:  return KIND_QVALUE;
            PH_VERSION: return KIND_VERSION;
            PH_LINE:    return KIND_HNAME;
            PH_HNAME:   return KIND_HNAME;
            PH_HVALUE:  return KIND_HVALUE;
            default:    return KIND_BODY;
        endcase
    endfunction

    function automatic void latch_error(input logic [1:0] code);
        if (err_latched == ST_OK)
            err_latched = code;
    endfunction

    function automatic token_t tokenize_byte(input logic [7:0] b, input logic l);
        token_t t;
        phase_t nx;
        t = '0;
        t.out_byte = b;
        t.request_end = l;
        t.field_kind = phase_kind(ph);
        nx = ph;
        if (ph == PH_BODY)
        begin
            t.byte_valid = 1'b1;
        end
        else if (b != CH_CR)
        begin
            case (ph)
                PH_METHOD:
                begin
                    if (b == CH_SPACE)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_PATH;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
                PH_PATH:
                begin
                    if (b == CH_SPACE)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_VERSION;
                    end
                    else if (b == CH_QMARK)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_QNAME;
                        q_fresh = 1'b1;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
                PH_QNAME:
                begin
                    q_fresh = 1'b0;
                    if (b == CH_EQUAL)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_QVALUE;
                    end
                    else if (b == CH_SPACE)
                    begin
                        t.field_end = 1'b1;
                        latch_error(ST_BAD_QUERY);
                        nx = PH_VERSION;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
                PH_QVALUE:
                begin
                    if (b == CH_AMP)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_QNAME;
                        q_fresh = 1'b1;
                    end
                    else if (b == CH_SPACE)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_VERSION;
                    end
                    else if (b == CH_LF)
                    begin
                        t.field_end = 1'b1;
                        latch_error(ST_BAD_QUERY);
                        nx = PH_QNAME;
                        q_fresh = 1'b1;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
                PH_VERSION:
                begin
                    if (b == CH_LF)
                    begin
                        t.field_end = 1'b1;
                        if (ver_cnt != VER_LEN || ver_bad)
                            latch_error(ST_BAD_VER);
                        ver_cnt = 4'd0;
                        ver_bad = 1'b0;
                        nx = PH_LINE;
                    end
                    else
                    begin
                        t.byte_valid = 1'b1;
                        if (ver_cnt < VER_LEN)
                        begin
                            if (b != VERSION_TEXT[8 * (7 - int'(ver_cnt)) +: 8])
                                ver_bad = 1'b1;
                            ver_cnt = ver_cnt + 4'd1;
                        end
                        else
                            ver_bad = 1'b1;
                    end
                end
                PH_LINE:
                begin
                    if (b == CH_LF)
                        nx = PH_BODY;
                    else if (b == CH_COLON)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_HVALUE;
                    end
                    else
                    begin
                        t.byte_valid = 1'b1;
                        nx = PH_HNAME;
                    end
                end
                PH_HNAME:
                begin
                    if (b == CH_COLON)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_HVALUE;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
                default:
                begin
                    if (b == CH_LF)
                    begin
                        t.field_end = 1'b1;
                        nx = PH_LINE;
                    end
                    else
                        t.byte_valid = 1'b1;
                end
            endcase
        end
        ph = nx;
        t.status = err_latched;
        if (l && err_latched == ST_OK && nx != PH_BODY)
            t.status = ST_TRUNC;
        if (l)
        begin
            ph = PH_METHOD;
            ver_cnt = 4'd0;
            ver_bad = 1'b0;
            q_fresh = 1'b0;
            err_latched = ST_OK;
        end
        return t;
    endfunction

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        token_t tok;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tok = tokenize_byte(s_tdata, s_tlast);
                if (row_typed)
                    tok = row_token;
                expected_tokens.push_back(tok);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: word %h kind %0d with nothing expected", $time, m_tdata,
                             m_tuser);
                    mismatches++;
                end
                else
                begin
                    tok = expected_tokens.pop_front();
                    compare_field("out_byte", tok.out_byte, m_tdata[7:0]);
                    compare_field("byte_valid", tok.byte_valid, m_tdata[8]);
                    compare_field("field_end", tok.field_end, m_tdata[9]);
                    compare_field("status", tok.status, m_tdata[11:10]);
                    compare_field("field_kind", tok.field_kind, m_tuser);
                    compare_field("request_end", tok.request_end, m_tlast);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_arm)
        begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (flow)
                FLOW_RECEIVER_STALL: m_tready <= ($urandom_range(0, 99) >= 57);
                FLOW_BOTH:           m_tready <= ($urandom_range(0, 99) >= 9);
                default:             m_tready <= 1'b1;
            endcase
        end
    end

    function automatic logic sender_rests();
        case (flow)
            FLOW_SENDER_IDLE: return $urandom_range(0, 99) < 57;
            FLOW_BOTH:        return $urandom_range(0, 99) < 9;
            default:          return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic l, input logic typed,
                             input token_t tok);
        while (sender_rests())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= l;
        row_typed <= typed;
        row_token <= tok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic append_text(input int n, input int noise_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                req_bytes.push_back(8'($urandom_range(0, 255)));
            else
                req_bytes.push_back(8'($urandom_range("z", "a")));
        end
    endtask

    task automatic append_line_end();
        if ($urandom_range(0, 1))
            req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endtask

    task automatic build_request();
        int pairs;
        int cut;
        req_bytes.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 20))
                req_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        append_text($urandom_range(1, 6), 2);
        req_bytes.push_back(CH_SPACE);
        req_bytes.push_back("/");
        append_text($urandom_range(0, 6), 2);
        if ($urandom_range(0, 1))
        begin
            req_bytes.push_back(CH_QMARK);
            pairs = $urandom_range(1, 3);
            for (int p = 0; p < pairs; p++)
            begin
                append_text($urandom_range(0, 4), 3);
                if ($urandom_range(0, 99) < 90)
                begin
                    req_bytes.push_back(CH_EQUAL);
                    append_text($urandom_range(0, 4), 3);
                end
                if (p != pairs - 1)
                    req_bytes.push_back(CH_AMP);
            end
        end
        req_bytes.push_back(CH_SPACE);
        for (int k = 0; k < 8; k++)
            req_bytes.push_back(VERSION_TEXT[8 * (7 - k) +: 8]);
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 2))
                0: req_bytes[req_bytes.size() - 1 - $urandom_range(0, 7)] =
                       8'($urandom_range(0, 255));
                1: void'(req_bytes.pop_back());
                default: req_bytes.push_back("1");
            endcase
        end
        append_line_end();
        repeat ($urandom_range(0, 3))
        begin
            append_text($urandom_range(0, 8), 2);
            req_bytes.push_back(CH_COLON);
            req_bytes.push_back(CH_SPACE);
            append_text($urandom_range(0, 10), 3);
            append_line_end();
        end
        append_line_end();
        repeat ($urandom_range(0, 8))
            req_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 10 && req_bytes.size() > 1)
        begin
            cut = $urandom_range(1, req_bytes.size() - 1);
            while (req_bytes.size() > cut)
                void'(req_bytes.pop_back());
        end
    endtask

    initial
    begin
        token_t tok;
        int sent;
        int req_idx;
        int n;

        // b, last, typed, valid, kind, field_end, status
        dir_rows = '{
            '{8'hFF,    1'b1, 1'b1, 1'b1, KIND_METHOD,  1'b0, ST_TRUNC},
            '{8'h00,    1'b1, 1'b1, 1'b1, KIND_METHOD,  1'b0, ST_TRUNC},
            '{"M",      1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_SPACE, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_QMARK, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_EQUAL, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b1, 1'b0, KIND_QVALUE,  1'b1, ST_BAD_QUERY},
            '{"k",      1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_SPACE, 1'b0, 1'b1, 1'b0, KIND_QNAME,   1'b1, ST_BAD_QUERY},
            '{"X",      1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b1, 1'b0, KIND_VERSION, 1'b1, ST_BAD_QUERY},
            '{CH_COLON, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_CR,    1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{8'hFF,    1'b1, 1'b1, 1'b1, KIND_BODY,    1'b0, ST_BAD_QUERY},
            '{CH_CR,    1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_SPACE, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_SPACE, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b0, 1'b1, 1'b0, KIND_VERSION, 1'b1, ST_BAD_VER},
            '{"a",      1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_COLON, 1'b0, 1'b0, 1'b0, KIND_METHOD,  1'b0, ST_OK},
            '{CH_LF,    1'b1, 1'b1, 1'b0, KIND_HVALUE,  1'b1, ST_BAD_VER}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sent = 0;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            tok = '0;
            tok.out_byte    = dir_rows[r].b;
            tok.byte_valid  = dir_rows[r].valid;
            tok.field_kind  = dir_rows[r].kind;
            tok.field_end   = dir_rows[r].fend;
            tok.request_end = dir_rows[r].l;
            tok.status      = dir_rows[r].status;
            send_word(dir_rows[r].b, dir_rows[r].l, dir_rows[r].typed, tok);
            sent++;
        end

        req_idx = 0;
        while (sent < TARGET_WORDS)
        begin
            flow = flow_t'((req_idx / 3) % 4);
            // stall the output long enough to back the input up
            if (req_idx == 4)
                hold_arm = 1'b1;
            build_request();
            n = req_bytes.size();
            for (int k = 0; k < n; k++)
                send_word(req_bytes[k], k == n - 1, 1'b0, '0);
            sent += n;
            req_idx++;
        end
        s_tvalid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/htk_pkg.sv
rtl/core/htk_step.sv
rtl/core/http_request_tokenizer_unit.sv
sim/tb_http_request_tokenizer_unit.sv
